FILE: src/assert_macros.svh
// Assertion macros shared by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define OST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

FILE: src/ost_pkg.sv
// Types and constants of the one-shot timer table.
package ost_pkg;

  localparam int CMD_W     = 3;
  localparam int TIME_W    = 64;
  localparam int ID_W      = 32;
  localparam int TASK_IN_W = 8;
  localparam int STATUS_W  = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ATTACH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // A tick releases at most this many waiters.
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [TIME_W-1:0]    now_ms;
    logic [TIME_W-1:0]    delay_ms;
    logic [ID_W-1:0]      timer_handle;
    logic [TASK_IN_W-1:0] task_ref;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      new_handle;
    logic                 is_expired;
    logic                 wake_valid;
    logic [TASK_IN_W-1:0] wake_task;
    logic                 last;
  } out_item_t;

endpackage

FILE: src/ost_if.sv
// Request and result channel interfaces of the timer table.
interface ost_in_if;
  import ost_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ost_out_if;
  import ost_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/ost_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ost_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/one_shot_timer_table_core.sv
// One-shot timer table core: TIMER_SLOTS timers scanned by one compare unit.
// A request is accepted, then scanned one slot per cycle through the entry RAM
// read port while a tick is not stalled on its results (an unused command
// code skips the scan), then its final result enters the output register,
// where it waits while results are stalled.
// Reset (rst_n low, synchronous) empties the table at once through per-slot
// flags and sets the id counter to one; no clearing pass is needed.
module one_shot_timer_table_core
  import ost_pkg::*;
#(
  parameter int TIMER_SLOTS = 32,
  parameter int TASK_BITS   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  ost_in_if.sink    in_chan,
  ost_out_if.source out_chan
);

  // Index width for slots and the stored waiter width. A task number never
  // carries more bits than the request field, so the waiter is capped there.
  localparam int IW    = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int WW    = (TASK_BITS < TASK_IN_W) ? TASK_BITS : TASK_IN_W;
  localparam int ENT_W = ID_W + TIME_W + WW;
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]  state_r, state_nxt;

  // Request captured at accept, with the new deadline already summed.
  logic [CMD_W-1:0]  cmd_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] dl_new_r;
  logic [ID_W-1:0]   handle_r;
  logic [WW-1:0]     task_r;

  // Per-slot flags live in flip-flops so that reset empties the table.
  logic [TIMER_SLOTS-1:0] active_r, active_nxt;
  logic [TIMER_SLOTS-1:0] waiter_v_r, waiter_v_nxt;
  logic [ID_W-1:0]        id_cnt_r, id_cnt_nxt;

  // Scan position and tick release count.
  logic [IW-1:0]    chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;

  // Result being built; during a tick it also holds the pending waiter.
  logic [STATUS_W-1:0] fin_status_r, fin_status_nxt;
  logic [ID_W-1:0]     fin_handle_r, fin_handle_nxt;
  logic                fin_expired_r, fin_expired_nxt;
  logic                fin_wvalid_r, fin_wvalid_nxt;
  logic [WW-1:0]       fin_wtask_r, fin_wtask_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Entry RAM port signals.
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IW-1:0]    ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  // Fields of the entry under inspection and the shared compare results.
  logic [ID_W-1:0]   e_id;
  logic [TIME_W-1:0] e_dl;
  logic [WW-1:0]     e_wt;
  logic              e_act, e_hw, e_expired, e_id_hit, at_end;
  logic              in_acc, out_free, scan_done, scan_stall;

  // Each entry holds id, deadline and waiter; the active and waiter flags
  // say which parts are meaningful.
  ost_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TIMER_SLOTS)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign e_id      = ram_rdata[ENT_W-1 -: ID_W];
  assign e_dl      = ram_rdata[WW +: TIME_W];
  assign e_wt      = ram_rdata[WW-1:0];
  assign e_act     = active_r[chk_idx_r];
  assign e_hw      = waiter_v_r[chk_idx_r];
  assign e_expired = now_r >= e_dl;
  assign e_id_hit  = e_act && (e_id == handle_r);
  assign at_end    = chk_idx_r == LAST_IDX;

  // The RAM read data always belongs to chk_idx_r while scanning: the address
  // for the following slot is issued in the same cycle that this one is
  // checked, and a stalled tick reissues the current address instead.
  always_comb begin
    state_nxt       = state_r;
    chk_idx_nxt     = chk_idx_r;
    n_nxt           = n_r;
    active_nxt      = active_r;
    waiter_v_nxt    = waiter_v_r;
    id_cnt_nxt      = id_cnt_r;
    fin_status_nxt  = fin_status_r;
    fin_handle_nxt  = fin_handle_r;
    fin_expired_nxt = fin_expired_r;
    fin_wvalid_nxt  = fin_wvalid_r;
    fin_wtask_nxt   = fin_wtask_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_data_nxt    = out_data_r;
    ram_we          = 1'b0;
    ram_waddr       = chk_idx_r;
    ram_wdata       = {id_cnt_r, dl_new_r, e_wt};
    ram_raddr       = '0;
    scan_done       = 1'b0;
    scan_stall      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          chk_idx_nxt     = '0;
          n_nxt           = '0;
          fin_status_nxt  = ST_OK;
          fin_handle_nxt  = '0;
          fin_expired_nxt = 1'b0;
          fin_wvalid_nxt  = 1'b0;
          fin_wtask_nxt   = '0;
          // Unused command codes skip the scan and answer with all zeros but last.
          if (in_chan.data.cmd inside {[CMD_CREATE:CMD_CLEAR]}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      S_SCAN: begin
        ram_raddr = chk_idx_r + 1'b1;
        case (cmd_r)
          CMD_CREATE: begin
            // The lowest free slot takes the next id; its old waiter field
            // is rewritten as is and stays hidden behind the cleared flag.
            if (!e_act) begin
              ram_we                     = 1'b1;
              ram_wdata                  = {id_cnt_r, dl_new_r, e_wt};
              active_nxt[chk_idx_r]      = 1'b1;
              waiter_v_nxt[chk_idx_r]    = 1'b0;
              id_cnt_nxt                 = id_cnt_r + 1'b1;
              fin_handle_nxt             = id_cnt_r;
              scan_done                  = 1'b1;
            end else if (at_end) begin
              fin_status_nxt = ST_NO_SLOT;
              scan_done      = 1'b1;
            end
          end

          CMD_QUERY: begin
            // An id that no active slot holds counts as expired.
            if (e_id_hit) begin
              fin_expired_nxt = e_expired;
              scan_done       = 1'b1;
            end else if (at_end) begin
              fin_expired_nxt = 1'b1;
              scan_done       = 1'b1;
            end
          end

          CMD_CANCEL: begin
            if (e_id_hit) begin
              fin_wvalid_nxt          = e_hw;
              fin_wtask_nxt           = e_hw ? e_wt : '0;
              active_nxt[chk_idx_r]   = 1'b0;
              waiter_v_nxt[chk_idx_r] = 1'b0;
              scan_done               = 1'b1;
            end else if (at_end) begin
              fin_status_nxt = ST_NOT_FOUND;
              scan_done      = 1'b1;
            end
          end

          CMD_ATTACH: begin
            // A new waiter replaces any earlier one on the slot.
            if (e_id_hit) begin
              ram_we                  = 1'b1;
              ram_wdata               = {e_id, e_dl, task_r};
              waiter_v_nxt[chk_idx_r] = 1'b1;
              scan_done               = 1'b1;
            end else if (at_end) begin
              fin_status_nxt = ST_NOT_FOUND;
              scan_done      = 1'b1;
            end
          end

          CMD_TICK: begin
            // Each released waiter is held back until the next one is found
            // or the scan ends, so that only the final one carries last.
            if (e_act && e_hw && e_expired) begin
              if (fin_wvalid_r && !out_free) begin
                scan_stall = 1'b1;
                ram_raddr  = chk_idx_r;
              end else begin
                if (fin_wvalid_r) begin
                  out_valid_nxt           = 1'b1;
                  out_data_nxt.status     = ST_OK;
                  out_data_nxt.new_handle = '0;
                  out_data_nxt.is_expired = 1'b0;
                  out_data_nxt.wake_valid = 1'b1;
                  out_data_nxt.wake_task  = TASK_IN_W'(fin_wtask_r);
                  out_data_nxt.last       = 1'b0;
                end
                fin_wvalid_nxt          = 1'b1;
                fin_wtask_nxt           = e_wt;
                active_nxt[chk_idx_r]   = 1'b0;
                waiter_v_nxt[chk_idx_r] = 1'b0;
                n_nxt                   = n_r + 1'b1;
                if (n_r == CNT_W'(MAX_RESULTS - 1)) begin
                  scan_done = 1'b1;
                end
              end
            end
            if (at_end && !scan_stall) begin
              scan_done = 1'b1;
            end
          end

          CMD_CLEAR: begin
            if (e_act && e_hw && (e_wt == task_r)) begin
              active_nxt[chk_idx_r]   = 1'b0;
              waiter_v_nxt[chk_idx_r] = 1'b0;
            end
            if (at_end) begin
              scan_done = 1'b1;
            end
          end

          default: begin
            scan_done = 1'b1;
          end
        endcase

        if (scan_done) begin
          state_nxt = S_OUT;
        end else if (!scan_stall) begin
          chk_idx_nxt = chk_idx_r + 1'b1;
        end
      end

      S_OUT: begin
        // The final result of the request always carries last.
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = fin_status_r;
          out_data_nxt.new_handle = fin_handle_r;
          out_data_nxt.is_expired = fin_expired_r;
          out_data_nxt.wake_valid = fin_wvalid_r;
          out_data_nxt.wake_task  = TASK_IN_W'(fin_wtask_r);
          out_data_nxt.last       = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      waiter_v_r  <= '0;
      id_cnt_r    <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      waiter_v_r  <= waiter_v_nxt;
      id_cnt_r    <= id_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    chk_idx_r     <= chk_idx_nxt;
    n_r           <= n_nxt;
    fin_status_r  <= fin_status_nxt;
    fin_handle_r  <= fin_handle_nxt;
    fin_expired_r <= fin_expired_nxt;
    fin_wvalid_r  <= fin_wvalid_nxt;
    fin_wtask_r   <= fin_wtask_nxt;
    out_data_r    <= out_data_nxt;
    if (in_acc) begin
      cmd_r    <= in_chan.data.cmd;
      now_r    <= in_chan.data.now_ms;
      dl_new_r <= in_chan.data.now_ms + in_chan.data.delay_ms;
      handle_r <= in_chan.data.timer_handle;
      task_r   <= in_chan.data.task_ref[WW-1:0];
    end
  end

  // One request at a time: the table takes a new one only when idle.
  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

`include "assert_macros.svh"

  // The scan never runs past the last slot.
  `OST_ASSERT_NOW(a_scan_in_range, state_r == S_SCAN, chk_idx_r <= LAST_IDX)

  // Only a tick may hand out a result that is not the final one.
  `OST_ASSERT_NOW(a_mid_result_tick, out_valid_r && !out_data_r.last, cmd_r == CMD_TICK)

  // The id counter moves only when a create finds a free slot.
  `OST_ASSERT_NOW(a_id_only_create, $past(rst_n) && !$stable(id_cnt_r),
                  $past(cmd_r) == CMD_CREATE && $past(state_r) == S_SCAN)

  // A tick never releases more waiters than one request allows.
  `OST_ASSERT_NOW(a_tick_bound, state_r == S_SCAN, n_r <= CNT_W'(MAX_RESULTS))

endmodule
